// ===== design/ihex_pkg.sv =====
// shared types and constants for the intel hex record to binary block
package ihex_pkg;

	localparam int MAX_DATA_BYTES = 32;
	localparam int BUF_AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
	localparam int OUT_TDATA_W = 112;

	localparam logic FUNC_NEW_FILE = 1'b0;
	localparam logic FUNC_BYTE = 1'b1;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF = 8'h01;
	localparam logic [7:0] REC_SEGMENT = 8'h02;
	localparam logic [7:0] REC_LINEAR = 8'h04;

	typedef enum logic [2:0] {
		STAT_OK = 3'd0,
		STAT_EOF = 3'd1,
		STAT_TYPE = 3'd2,
		STAT_SUM = 3'd3,
		STAT_LEN = 3'd4,
		STAT_BACK = 3'd5
	} status_t;

	// finished record as seen by the emit side
	typedef struct packed {
		logic new_file;
		logic valid;
		logic len_ok;
		logic sum_ok;
		logic [7:0] data_length;
		logic [15:0] record_offset;
		logic [7:0] record_type;
	} rx_rec_t;

	typedef struct packed {
		logic idle;
		logic stopped;
	} emit_stat_t;

	typedef struct packed {
		logic en;
		logic [BUF_AW-1:0] addr;
		logic [7:0] data;
	} buf_wr_t;

	typedef struct packed {
		logic kind;
		logic [31:0] address;
		logic [7:0] data_byte;
		logic [31:0] gap_fill;
		status_t status;
		logic [31:0] first_address;
		logic last;
	} result_t;

endpackage

// ===== design/ihex_ram.sv =====
// record data buffer, one write port and one registered read port
module ihex_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8,
	parameter int AW = 5
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/ihex_rx.sv =====
// byte intake: header fields, running checksum, byte count and buffer writes
module ihex_rx import ihex_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic s_axis_tlast,
	input logic s_axis_tuser,
	input emit_stat_t emit_stat,
	output rx_rec_t rec,
	output buf_wr_t buf_wr
);

	logic [8:0] cnt_q;
	logic [7:0] sum_q;
	logic [7:0] dl_q;
	logic [15:0] off_q;
	logic [7:0] type_q;
	logic rec_valid_q;
	logic len_ok_q;
	logic sum_ok_q;
	logic acc;
	logic take_byte;
	logic [8:0] idx9;
	logic [9:0] total;

	assign s_axis_tready = emit_stat.idle && !rec_valid_q;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign take_byte = acc && (s_axis_tuser == FUNC_BYTE) && !emit_stat.stopped;
	assign idx9 = cnt_q - 9'd4;
	assign total = {1'b0, cnt_q} + 10'd1;

	assign buf_wr.en = take_byte && !s_axis_tlast && (cnt_q >= 9'd4)
		&& (idx9 < 9'(MAX_DATA_BYTES));
	assign buf_wr.addr = idx9[BUF_AW-1:0];
	assign buf_wr.data = s_axis_tdata;

	assign rec.new_file = acc && (s_axis_tuser == FUNC_NEW_FILE);
	assign rec.valid = rec_valid_q;
	assign rec.len_ok = len_ok_q;
	assign rec.sum_ok = sum_ok_q;
	assign rec.data_length = dl_q;
	assign rec.record_offset = off_q;
	assign rec.record_type = type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			dl_q <= '0;
			off_q <= '0;
			type_q <= '0;
			rec_valid_q <= 1'b0;
			len_ok_q <= 1'b0;
			sum_ok_q <= 1'b0;
		end else begin
			rec_valid_q <= 1'b0;
			if (rec.new_file) begin
				cnt_q <= '0;
				sum_q <= '0;
				dl_q <= '0;
				off_q <= '0;
				type_q <= '0;
			end else if (take_byte) begin
				if (s_axis_tlast) begin
					rec_valid_q <= 1'b1;
					len_ok_q <= (total >= 10'd5) && (dl_q <= 8'(MAX_DATA_BYTES))
						&& (total == ({2'b00, dl_q} + 10'd5));
					sum_ok_q <= (sum_q + s_axis_tdata) == 8'h00;
					cnt_q <= '0;
					sum_q <= '0;
				end else begin
					if (cnt_q == 9'd0) begin
						dl_q <= s_axis_tdata;
					end else if (cnt_q == 9'd1) begin
						off_q[15:8] <= s_axis_tdata;
					end else if (cnt_q == 9'd2) begin
						off_q[7:0] <= s_axis_tdata;
					end else if (cnt_q == 9'd3) begin
						type_q <= s_axis_tdata;
					end
					sum_q <= sum_q + s_axis_tdata;
					if (cnt_q != 9'd511) begin
						cnt_q <= cnt_q + 9'd1;
					end
				end
			end
		end
	end

endmodule

// ===== design/ihex_emit.sv =====
// record evaluation, address bases and the buffer drain into the result register
module ihex_emit import ihex_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rx_rec_t rec,
	output emit_stat_t emit_stat,
	output logic rd_en,
	output logic [BUF_AW-1:0] rd_addr,
	input logic [7:0] rd_data,
	output logic out_valid,
	input logic out_ready,
	output result_t out_res
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PLACE = 9'b000000010,
		S_DRD = 9'b000000100,
		S_DOUT = 9'b000001000,
		S_BRD0 = 9'b000010000,
		S_BRD1 = 9'b000100000,
		S_BSET = 9'b001000000,
		S_STAT = 9'b010000000,
		S_HOLD = 9'b100000000
	} emit_state_t;

	emit_state_t state_q;
	logic [19:0] seg_q;
	logic [31:0] lin_q;
	logic [31:0] next_q;
	logic seen_q;
	logic [31:0] start_q;
	logic stopped_q;
	logic [31:0] cur_q;
	logic [31:0] gap_q;
	logic [31:0] addr_q;
	logic [BUF_AW-1:0] idx_q;
	logic [7:0] hi_q;
	status_t status_q;
	logic out_valid_q;
	result_t res_q;

	logic out_free;
	logic [31:0] base;
	logic [31:0] eff_next;
	logic [32:0] diff;
	logic [7:0] idx_ext;
	logic [15:0] value;

	assign out_free = !out_valid_q || out_ready;
	assign base = (seg_q != 20'd0) ? {12'd0, seg_q} : lin_q;
	assign eff_next = seen_q ? next_q : cur_q;
	assign diff = {1'b0, cur_q} - {1'b0, eff_next};
	assign idx_ext = {{(8-BUF_AW){1'b0}}, idx_q};
	assign value = {hi_q, rd_data};

	assign emit_stat.idle = (state_q == S_IDLE);
	assign emit_stat.stopped = stopped_q;
	assign out_valid = out_valid_q;
	assign out_res = res_q;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q;
		unique case (state_q)
			S_DRD: begin
				rd_en = 1'b1;
			end
			S_BRD0: begin
				rd_en = 1'b1;
				rd_addr = '0;
			end
			S_BRD1: begin
				rd_en = 1'b1;
				rd_addr = BUF_AW'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seg_q <= '0;
			lin_q <= '0;
			next_q <= '0;
			seen_q <= 1'b0;
			start_q <= '1;
			stopped_q <= 1'b0;
			out_valid_q <= 1'b0;
			status_q <= STAT_OK;
			idx_q <= '0;
			cur_q <= '0;
			gap_q <= '0;
			addr_q <= '0;
			hi_q <= '0;
			res_q <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rec.new_file) begin
						seg_q <= '0;
						lin_q <= '0;
						next_q <= '0;
						seen_q <= 1'b0;
						start_q <= '1;
						stopped_q <= 1'b0;
					end else if (rec.valid) begin
						state_q <= S_STAT;
						if (!rec.len_ok) begin
							status_q <= STAT_LEN;
						end else if (!rec.sum_ok) begin
							status_q <= STAT_SUM;
						end else begin
							case (rec.record_type)
								REC_DATA: begin
									cur_q <= base + {16'd0, rec.record_offset};
									state_q <= S_PLACE;
								end
								REC_EOF: begin
									status_q <= STAT_EOF;
								end
								REC_SEGMENT, REC_LINEAR: begin
									if (rec.data_length != 8'd2) begin
										status_q <= STAT_LEN;
									end else begin
										state_q <= S_BRD0;
									end
								end
								default: begin
									status_q <= STAT_TYPE;
								end
							endcase
						end
					end
				end
				S_PLACE: begin
					if (diff[32]) begin
						status_q <= STAT_BACK;
						state_q <= S_STAT;
					end else begin
						if (!seen_q) begin
							seen_q <= 1'b1;
							start_q <= cur_q;
						end
						gap_q <= diff[31:0];
						addr_q <= cur_q;
						idx_q <= '0;
						status_q <= STAT_OK;
						if (rec.data_length != 8'd0) begin
							next_q <= cur_q + {24'd0, rec.data_length};
							state_q <= S_DRD;
						end else begin
							next_q <= eff_next;
							state_q <= S_STAT;
						end
					end
				end
				S_DRD: begin
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q.kind <= KIND_DATA;
						res_q.address <= addr_q;
						res_q.data_byte <= rd_data;
						res_q.gap_fill <= gap_q;
						res_q.status <= STAT_OK;
						res_q.first_address <= start_q;
						res_q.last <= 1'b0;
						addr_q <= addr_q + 32'd1;
						gap_q <= '0;
						idx_q <= idx_q + BUF_AW'(1);
						if ((idx_ext + 8'd1) == rec.data_length) begin
							state_q <= S_STAT;
						end else begin
							state_q <= S_DRD;
						end
					end
				end
				S_BRD0: begin
					state_q <= S_BRD1;
				end
				S_BRD1: begin
					// entry 0 is on the read port here, entry 1 follows
					hi_q <= rd_data;
					state_q <= S_BSET;
				end
				S_BSET: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (rec.record_type == REC_SEGMENT) begin
						seg_q <= {value, 4'd0};
						lin_q <= '0;
					end else begin
						lin_q <= {value, 16'd0};
						seg_q <= '0;
					end
					status_q <= STAT_OK;
					state_q <= S_STAT;
				end
				S_STAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q.kind <= KIND_STATUS;
						res_q.address <= '0;
						res_q.data_byte <= '0;
						res_q.gap_fill <= '0;
						res_q.status <= status_q;
						res_q.first_address <= start_q;
						res_q.last <= 1'b1;
						if (status_q != STAT_OK) begin
							stopped_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_rec_only_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rec.valid |-> (state_q == S_IDLE))
		else $error("record finished while emit side busy");

	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STAT && out_free && status_q != STAT_OK) |=> stopped_q)
		else $error("error status did not stop the block");

	a_drain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOUT) |-> (idx_ext < rec.data_length))
		else $error("buffer drain index past record length");

	a_back_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE && diff[32]) |=> (state_q == S_STAT))
		else $error("backward record did not go straight to status");

endmodule

// ===== design/intel_hex_record_to_binary.sv =====
// top level of the intel hex record to binary block
// Record bytes are taken one per cycle into a 32-entry buffer memory while the header
// fields and checksum are collected. The transaction carrying the checksum byte ends
// the record; the input then stalls while the record is evaluated. Each byte of a data
// record is read from the buffer's registered read port and then loaded into the output
// register, waiting while the output is stalled, before the status result is loaded; an
// address base record first reads both buffer entries and other records go straight to
// their status. Results wait in an output register, so the input reopens while the final
// status is still pending. The buffer needs no clearing after reset.
module intel_hex_record_to_binary import ihex_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // record_byte
	input logic s_axis_tlast, // line_end
	input logic s_axis_tuser, // func
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// address, data_byte, gap_fill, status, first_address, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast, // last
	output logic m_axis_tuser // kind
);

	emit_stat_t emit_stat;
	rx_rec_t rec;
	buf_wr_t buf_wr;
	logic rd_en;
	logic [BUF_AW-1:0] rd_addr;
	logic [7:0] rd_data;
	result_t res;

	ihex_rx u_rx (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.emit_stat(emit_stat),
		.rec(rec),
		.buf_wr(buf_wr)
	);

	ihex_ram #(
		.DEPTH(MAX_DATA_BYTES),
		.WIDTH(8),
		.AW(BUF_AW)
	) u_ram (
		.clk(clk),
		.wr_en(buf_wr.en),
		.wr_addr(buf_wr.addr),
		.wr_data(buf_wr.data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	ihex_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.rec(rec),
		.emit_stat(emit_stat),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(res)
	);

	assign m_axis_tdata = {5'd0, res.first_address, res.status, res.gap_fill,
		res.data_byte, res.address};
	assign m_axis_tlast = res.last;
	assign m_axis_tuser = res.kind;

endmodule
